// File: rtl/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int MAX_PAGES           = 4096;
  localparam int PAGE_BYTES          = 4096;
  localparam int EARLY_RESERVE_PAGES = 16;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int WORD_BITS  = 32;
  localparam int LANE_W     = $clog2(WORD_BITS);
  localparam int WORDS      = MAX_PAGES / WORD_BITS;
  localparam int WORD_AW    = $clog2(WORDS);
  localparam int PAGE_IDX_W = $clog2(MAX_PAGES);

  localparam int FUNC_W = 2;
  localparam int PAGE_W = 24;
  localparam int CNT_W  = 13;
  localparam int KEND_W = 36;

  localparam int CFG_DW = 64;
  localparam int CFG_AW = 4;

  localparam logic [PAGE_W-1:0] PAGE_LIMIT = 24'hFFFFFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RESTART = 2'd0,
    FUNC_BUILD   = 2'd1,
    FUNC_ALLOC   = 2'd2,
    FUNC_FREE    = 2'd3
  } func_e;

  typedef enum logic {
    CFG_PAGE_COUNT = 1'b0,
    CFG_IMAGE_END  = 1'b1
  } cfg_idx_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_BUILD  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_TAKE   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

endpackage

// File: rtl/bpa_if.sv
`timescale 1ns / 1ps
interface bpa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bpa_pkg::FUNC_W-1:0]  func;
  logic [bpa_pkg::PAGE_W-1:0]  page;
  logic [bpa_pkg::CNT_W-1:0]   count;

  modport source (output valid, output func, output page, output count, input ready);
  modport sink   (input valid, input func, input page, input count, output ready);
endinterface

interface bpa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [bpa_pkg::PAGE_W-1:0]  start_page;
  logic [bpa_pkg::CNT_W-1:0]   free_count;
  logic [bpa_pkg::CNT_W-1:0]   used_count;

  modport source (output valid, output ok, output start_page, output free_count,
                  output used_count, input ready);
  modport sink   (input valid, input ok, input start_page, input free_count,
                  input used_count, output ready);
endinterface

// File: rtl/bitmap_page_allocator_unit.sv
`timescale 1ns / 1ps
// Bitmap first-fit page allocator.
// req_i carries one request (func, page, count); rsp_o returns one response per
// request (ok, start_page, free_count, used_count). Both use valid/ready.
// Configuration (page count at 0x0, kernel image end at 0x8) goes through the APB
// port and must be written only while the block is idle; the block does not
// enforce this. One request is in work at a time; req_i.ready is high when the
// engine idles. Restart, ignored or pre-build requests go from decode straight to
// the done state and load the response register. Build sweeps every map word.
// Allocate scans one 32-page word per cycle from word 0 until the run is found,
// then rewrites the covered words one per cycle. Free rewrites the covered words
// one per cycle. The one-read, one-write map memory sets these rates.
// The response sits in an output register; a stalled receiver only holds that
// register, and the next request is accepted meanwhile but completes only once
// the register is free.
// Reset clears control state, counters, configuration and response valid. The
// map memory is not cleared: it is read only after a build rewrites every word.
module bitmap_page_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bpa_req_if.sink                     req_i,
  bpa_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpa_pkg::CFG_AW-1:0]  paddr,
  input  logic [bpa_pkg::CFG_DW-1:0]  pwdata,
  output logic [bpa_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int CW = bpa_pkg::CNT_W;
  localparam int PW = bpa_pkg::PAGE_W;
  localparam int IW = bpa_pkg::PAGE_IDX_W;
  localparam int AW = bpa_pkg::WORD_AW;
  localparam int LW = bpa_pkg::LANE_W;
  localparam int NB = bpa_pkg::WORD_BITS;
  localparam int KW = bpa_pkg::KEND_W;

  bpa_pkg::state_e state_q, state_d;

  logic [CW-1:0] page_cnt_q;
  logic [KW-1:0] image_end_q;

  logic [PW-1:0] bump_q, bump_d;
  logic          built_q, built_d;
  logic [CW-1:0] free_q, free_d;
  logic [CW-1:0] used_q, used_d;

  logic [bpa_pkg::FUNC_W-1:0] func_q;
  logic [PW-1:0] page_q;
  logic [CW-1:0] count_q;

  logic [AW-1:0] rd_w_q, rd_w_d;
  logic [CW-1:0] run_q, run_d;
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic          set_q, set_d;
  logic          res_ok_q, res_ok_d;
  logic [PW-1:0] res_start_q, res_start_d;

  logic          rsp_valid_q;
  logic          rsp_ok_q;
  logic [PW-1:0] rsp_start_q;
  logic [CW-1:0] rsp_free_q, rsp_used_q;

  logic [NB-1:0] map_mem [bpa_pkg::WORDS];
  logic [NB-1:0] rdata_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [NB-1:0] mem_wdata;

  logic [CW-1:0] tot;
  logic          req_acc;
  logic          cfg_wr;
  logic          out_free;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= map_mem[mem_raddr];
    end
  end

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (bpa_pkg::cfg_idx_e'(paddr[3]) == bpa_pkg::CFG_IMAGE_END) ?
                  bpa_pkg::CFG_DW'(image_end_q) : bpa_pkg::CFG_DW'(page_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_cnt_q  <= '0;
      image_end_q <= '0;
    end else if (cfg_wr) begin
      if (bpa_pkg::cfg_idx_e'(paddr[3]) == bpa_pkg::CFG_IMAGE_END) begin
        image_end_q <= pwdata[KW-1:0];
      end else begin
        page_cnt_q <= pwdata[CW-1:0];
      end
    end
  end

  assign tot = (page_cnt_q > CW'(bpa_pkg::MAX_PAGES)) ? CW'(bpa_pkg::MAX_PAGES)
                                                       : page_cnt_q;

  assign req_i.ready = (state_q == bpa_pkg::S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  // restart / bump arithmetic
  logic [KW:0]   ke_round;
  logic [KW:0]   bump_raw;
  logic [PW-1:0] bump_rst;
  logic [PW:0]   bump_sum;
  assign ke_round = {1'b0, image_end_q} + (KW+1)'(bpa_pkg::PAGE_BYTES - 1);
  assign bump_raw = (ke_round >> bpa_pkg::PAGE_SHIFT)
                  + (KW+1)'(bpa_pkg::EARLY_RESERVE_PAGES);
  assign bump_rst = (bump_raw > (KW+1)'(bpa_pkg::PAGE_LIMIT)) ? bpa_pkg::PAGE_LIMIT
                                                               : bump_raw[PW-1:0];
  assign bump_sum = {1'b0, bump_q} + (PW+1)'(count_q);

  // build counts
  logic [CW-1:0] bld_used;
  assign bld_used = (bump_q < PW'(tot)) ? bump_q[CW-1:0] : tot;

  // free run length and counters
  logic [CW-1:0] fr_room, fr_n;
  logic [CW:0]   fr_fsum;
  logic [CW-1:0] fr_free, fr_used;
  assign fr_room = tot - page_q[CW-1:0];
  assign fr_n    = (page_q >= PW'(tot)) ? '0 : ((count_q < fr_room) ? count_q : fr_room);
  assign fr_fsum = {1'b0, free_q} + {1'b0, fr_n};
  assign fr_free = (free_q >= tot) ? free_q :
                   ((fr_fsum > {1'b0, tot}) ? tot : fr_fsum[CW-1:0]);
  assign fr_used = (used_q > fr_n) ? used_q - fr_n : '0;

  // allocate counters
  logic [CW:0]   al_usum;
  logic [CW-1:0] al_free, al_used;
  assign al_usum = {1'b0, used_q} + {1'b0, count_q};
  assign al_free = (free_q > count_q) ? free_q - count_q : '0;
  assign al_used = (used_q >= tot) ? used_q :
                   ((al_usum > {1'b0, tot}) ? tot : al_usum[CW-1:0]);

  // per-word lane logic
  logic [NB-1:0] lane_free, lane_hit, lane_in, lane_bld;
  logic [LW-1:0] lane_lz [NB];
  logic [NB-1:0] lane_hz;
  logic [CW-1:0] lane_run [NB];
  logic          scan_found;
  logic [LW-1:0] scan_j;
  logic [CW-1:0] scan_end, scan_first, scan_carry;

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      lane_free[j] = rdata_q[j] && ({1'b0, rd_w_q, LW'(j)} < tot);
      lane_in[j]   = ({rd_w_q, LW'(j)} >= lo_q) && ({rd_w_q, LW'(j)} <= hi_q);
      lane_bld[j]  = ({1'b0, rd_w_q, LW'(j)} >= used_q);
    end
    for (int j = 0; j < NB; j++) begin
      lane_hz[j] = 1'b0;
      lane_lz[j] = '0;
      for (int k = 0; k <= j; k++) begin
        if (!lane_free[k]) begin
          lane_hz[j] = 1'b1;
          lane_lz[j] = LW'(k);
        end
      end
      lane_run[j] = lane_hz[j] ? (CW'(j) - CW'(lane_lz[j])) : (run_q + CW'(j + 1));
      lane_hit[j] = lane_free[j] && (lane_run[j] >= count_q);
    end
    scan_found = 1'b0;
    scan_j     = '0;
    for (int j = NB - 1; j >= 0; j--) begin
      if (lane_hit[j]) begin
        scan_found = 1'b1;
        scan_j     = LW'(j);
      end
    end
  end

  assign scan_end   = {1'b0, rd_w_q, scan_j};
  assign scan_first = scan_end - count_q + CW'(1);
  assign scan_carry = lane_hz[NB-1] ? (CW'(NB - 1) - CW'(lane_lz[NB-1]))
                                    : (run_q + CW'(NB));

  // control
  always_comb begin
    state_d     = state_q;
    bump_d      = bump_q;
    built_d     = built_q;
    free_d      = free_q;
    used_d      = used_q;
    rd_w_d      = rd_w_q;
    run_d       = run_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    set_d       = set_q;
    res_ok_d    = res_ok_q;
    res_start_d = res_start_q;
    mem_re      = 1'b0;
    mem_raddr   = rd_w_q;
    mem_we      = 1'b0;
    mem_waddr   = rd_w_q;
    mem_wdata   = '0;

    case (state_q)
      bpa_pkg::S_IDLE: begin
        if (req_acc) begin
          state_d = bpa_pkg::S_DECODE;
        end
      end
      bpa_pkg::S_DECODE: begin
        res_ok_d    = 1'b1;
        res_start_d = '0;
        state_d     = bpa_pkg::S_DONE;
        case (bpa_pkg::func_e'(func_q))
          bpa_pkg::FUNC_RESTART: begin
            bump_d  = bump_rst;
            free_d  = '0;
            used_d  = '0;
            built_d = 1'b0;
          end
          bpa_pkg::FUNC_BUILD: begin
            if (!built_q) begin
              used_d  = bld_used;
              free_d  = tot - bld_used;
              built_d = 1'b1;
              rd_w_d  = '0;
              state_d = bpa_pkg::S_BUILD;
            end
          end
          bpa_pkg::FUNC_ALLOC: begin
            if (count_q == '0) begin
              res_ok_d = 1'b0;
            end else if (!built_q) begin
              if (bump_sum > {1'b0, bpa_pkg::PAGE_LIMIT}) begin
                res_ok_d = 1'b0;
              end else begin
                res_start_d = bump_q;
                bump_d      = bump_sum[PW-1:0];
              end
            end else begin
              run_d     = '0;
              rd_w_d    = '0;
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_d   = bpa_pkg::S_SCAN;
            end
          end
          bpa_pkg::FUNC_FREE: begin
            if (page_q != '0 && count_q != '0 && built_q && fr_n != '0) begin
              free_d    = fr_free;
              used_d    = fr_used;
              set_d     = 1'b1;
              lo_d      = page_q[IW-1:0];
              hi_d      = IW'(page_q[CW-1:0] + fr_n - CW'(1));
              rd_w_d    = page_q[IW-1:LW];
              mem_re    = 1'b1;
              mem_raddr = page_q[IW-1:LW];
              state_d   = bpa_pkg::S_TAKE;
            end
          end
          default: begin
            state_d = bpa_pkg::S_DONE;
          end
        endcase
      end
      bpa_pkg::S_BUILD: begin
        mem_we    = 1'b1;
        mem_waddr = rd_w_q;
        mem_wdata = lane_bld;
        if (rd_w_q == AW'(bpa_pkg::WORDS - 1)) begin
          state_d = bpa_pkg::S_DONE;
        end else begin
          rd_w_d = rd_w_q + AW'(1);
        end
      end
      bpa_pkg::S_SCAN: begin
        if (scan_found) begin
          free_d      = al_free;
          used_d      = al_used;
          set_d       = 1'b0;
          lo_d        = scan_first[IW-1:0];
          hi_d        = scan_end[IW-1:0];
          res_start_d = PW'(scan_first);
          rd_w_d      = scan_first[IW-1:LW];
          mem_re      = 1'b1;
          mem_raddr   = scan_first[IW-1:LW];
          state_d     = bpa_pkg::S_TAKE;
        end else if (rd_w_q == AW'(bpa_pkg::WORDS - 1)) begin
          res_ok_d = 1'b0;
          state_d  = bpa_pkg::S_DONE;
        end else begin
          run_d     = scan_carry;
          rd_w_d    = rd_w_q + AW'(1);
          mem_re    = 1'b1;
          mem_raddr = rd_w_q + AW'(1);
        end
      end
      bpa_pkg::S_TAKE: begin
        mem_we    = 1'b1;
        mem_waddr = rd_w_q;
        for (int j = 0; j < NB; j++) begin
          mem_wdata[j] = lane_in[j] ? set_q : rdata_q[j];
        end
        if (rd_w_q == hi_q[IW-1:LW]) begin
          state_d = bpa_pkg::S_DONE;
        end else begin
          rd_w_d    = rd_w_q + AW'(1);
          mem_re    = 1'b1;
          mem_raddr = rd_w_q + AW'(1);
        end
      end
      bpa_pkg::S_DONE: begin
        if (out_free) begin
          state_d = bpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpa_pkg::S_IDLE;
      bump_q  <= '0;
      built_q <= 1'b0;
      free_q  <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      bump_q  <= bump_d;
      built_q <= built_d;
      free_q  <= free_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      func_q  <= req_i.func;
      page_q  <= req_i.page;
      count_q <= req_i.count;
    end
    rd_w_q      <= rd_w_d;
    run_q       <= run_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    set_q       <= set_d;
    res_ok_q    <= res_ok_d;
    res_start_q <= res_start_d;
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (state_q == bpa_pkg::S_DONE && out_free) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bpa_pkg::S_DONE && out_free) begin
      rsp_ok_q    <= res_ok_q;
      rsp_start_q <= res_start_q;
      rsp_free_q  <= free_q;
      rsp_used_q  <= used_q;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.ok         = rsp_ok_q;
  assign rsp_o.start_page = rsp_start_q;
  assign rsp_o.free_count = rsp_free_q;
  assign rsp_o.used_count = rsp_used_q;

  // assertions
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> state_q == bpa_pkg::S_DECODE)
    else $error("request accept did not enter decode");

  a_map_walk_built: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpa_pkg::S_SCAN || state_q == bpa_pkg::S_TAKE) |-> built_q)
    else $error("map walked while not built");

  a_take_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bpa_pkg::S_TAKE |->
      (rd_w_q >= lo_q[IW-1:LW]) && (rd_w_q <= hi_q[IW-1:LW]) && (lo_q <= hi_q))
    else $error("run rewrite outside its word range");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == bpa_pkg::S_DONE)
    else $error("response raised outside completion");

endmodule
